/* rtl/nta_pkg.sv */
// shared constants, codes and types for the neighbor table with aging
package nta_pkg;

   // defaults for the top-level parameters
   localparam int NUM_NODES_DEF = 16;
   localparam int ENTRIES_DEF   = 5;

   // field widths
   localparam int MODE_W  = 2;
   localparam int ID_W    = 4;
   localparam int TIME_W  = 32;
   localparam int STAT_W  = 3;
   localparam int OCNT_W  = 3;

   // timeout register value after reset
   localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd30000;

   typedef enum logic [MODE_W-1:0] {
      MODE_TOUCH  = 2'd0,
      MODE_ADD    = 2'd1,
      MODE_PRUNE  = 2'd2,
      MODE_LOOKUP = 2'd3
   } mode_type;

   typedef enum logic [STAT_W-1:0] {
      ST_REFRESHED = 3'd0,
      ST_INSERTED  = 3'd1,
      ST_FULL      = 3'd2,
      ST_SELF      = 3'd3,
      ST_NONE      = 3'd4
   } status_type;

endpackage

/* rtl/nta_if.sv */
// request and response channel interfaces
interface nta_req_if;
   import nta_pkg::*;
   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] mode;
   logic [ID_W-1:0]   node_id;
   logic [ID_W-1:0]   nbr_id;
   logic [TIME_W-1:0] now_ms;
   modport source (output valid, mode, node_id, nbr_id, now_ms, input ready);
   modport sink   (input valid, mode, node_id, nbr_id, now_ms, output ready);
endinterface

interface nta_rsp_if;
   import nta_pkg::*;
   logic              valid;
   logic              ready;
   logic [STAT_W-1:0] status;
   logic              reachable;
   logic [OCNT_W-1:0] entry_count;
   logic [OCNT_W-1:0] removed_count;
   modport source (output valid, status, reachable, entry_count, removed_count,
                   input ready);
   modport sink   (input valid, status, reachable, entry_count, removed_count,
                   output ready);
endinterface

/* rtl/nta_ram.sv */
// generic single-write, single-read ram with registered read data
module nta_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule

/* rtl/neighbor_table_with_aging.sv */
// top level: per-node neighbor tables held as rows of one ram, aged by a timeout
// an item goes through row read, compare (S_EVAL) and write back with the result (S_WRITE)
// a new item is taken only in S_IDLE; the ram row read-modify-write sets the pace
// one item in flight at a time, so a row write always lands before the next read
// reset: all tables empty (row valid bits cleared), timeout_ms back to 30000
// no clearing pass: a row that was never written reads as an empty table
module neighbor_table_with_aging #(
   parameter int NUM_NODES = nta_pkg::NUM_NODES_DEF,
   parameter int ENTRIES   = nta_pkg::ENTRIES_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   nta_req_if.sink                    req_ch,
   nta_rsp_if.source                  rsp_ch,
   input  logic                       csr_wr_en,
   input  logic [nta_pkg::TIME_W-1:0] csr_wr_data
);
   import nta_pkg::*;

   // row layout: {count, ids[ENTRIES], times[ENTRIES]}
   localparam int AW     = $clog2(NUM_NODES);
   localparam int CNT_W  = $clog2(ENTRIES + 1);
   localparam int IDS_W  = ENTRIES * ID_W;
   localparam int TIMS_W = ENTRIES * TIME_W;
   localparam int ROW_W  = CNT_W + IDS_W + TIMS_W;
   localparam int XID_W  = 9;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EVAL,
      S_WRITE
   } state_type;

   state_type state_ff;

   // configuration
   logic [TIME_W-1:0] timeout_ff;

   // captured item
   logic [MODE_W-1:0] mode_ff;
   logic [ID_W-1:0]   node_ff;
   logic [ID_W-1:0]   nb_ff;
   logic [TIME_W-1:0] now_ff;
   logic [AW-1:0]     addr_ff;
   logic              node_ok_ff;
   logic              nb_ok_ff;
   logic              row_vld_ff;

   // per-row valid bits: a never-written row is an empty table
   logic [NUM_NODES-1:0] row_valid_ff;

   // ram ports
   logic             ram_wr_en;
   logic [ROW_W-1:0] ram_wr_data;
   logic [ROW_W-1:0] ram_rd_data;
   logic             req_fire;

   // request decode
   logic [XID_W-1:0] node_ext;
   logic [XID_W-1:0] nb_ext;
   logic [AW-1:0]    req_addr;

   // row as read
   logic [CNT_W-1:0]                 cnt_rd;
   logic [ENTRIES-1:0][ID_W-1:0]     ids_rd;
   logic [ENTRIES-1:0][TIME_W-1:0]   times_rd;
   logic [ENTRIES-1:0]               hit_in;
   logic [ENTRIES-1:0]               keep_in;

   // evaluated row
   logic [CNT_W-1:0]                 cnt_ff;
   logic [ENTRIES-1:0][ID_W-1:0]     ids_ff;
   logic [ENTRIES-1:0][TIME_W-1:0]   times_ff;
   logic [ENTRIES-1:0]               hit_ff;
   logic [ENTRIES-1:0]               keep_ff;

   // updated row and result
   logic [CNT_W-1:0]                 cnt_new;
   logic [ENTRIES-1:0][ID_W-1:0]     ids_new;
   logic [ENTRIES-1:0][TIME_W-1:0]   times_new;
   status_type                       status_new;
   logic                             reach_new;
   logic [CNT_W-1:0]                 removed_new;
   logic                             commit;

   // result register
   logic              rsp_valid_ff;
   logic [STAT_W-1:0] rsp_status_ff;
   logic              rsp_reach_ff;
   logic [OCNT_W-1:0] rsp_count_ff;
   logic [OCNT_W-1:0] rsp_removed_ff;

   // ------------------------------------------------------------------
   // handshakes
   // ------------------------------------------------------------------
   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;

   // the result register frees up when empty or taken this cycle
   assign commit = (state_ff == S_WRITE) && (!rsp_valid_ff || rsp_ch.ready);

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.status        = rsp_status_ff;
   assign rsp_ch.reachable     = rsp_reach_ff;
   assign rsp_ch.entry_count   = rsp_count_ff;
   assign rsp_ch.removed_count = rsp_removed_ff;

   // ids are 4 bits; widen so range checks work for up to 511 nodes
   assign node_ext = XID_W'(req_ch.node_id);
   assign nb_ext   = XID_W'(req_ch.nbr_id);
   assign req_addr = node_ext[AW-1:0];

   // ------------------------------------------------------------------
   // table rows
   // ------------------------------------------------------------------
   nta_ram #(
      .WIDTH (ROW_W),
      .DEPTH (NUM_NODES)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (addr_ff),
      .wr_data (ram_wr_data),
      .rd_en   (req_fire),
      .rd_addr (req_addr),
      .rd_data (ram_rd_data)
   );

   // out-of-range nodes never write the ram
   assign ram_wr_en   = commit && node_ok_ff;
   assign ram_wr_data = {cnt_new, ids_new, times_new};

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
      end else if (csr_wr_en) begin
         timeout_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else if (ram_wr_en) begin
         row_valid_ff[addr_ff] <= 1'b1;
      end
   end

   // capture the item together with the ram read
   always_ff @(posedge clock) begin
      if (req_fire) begin
         mode_ff    <= req_ch.mode;
         node_ff    <= req_ch.node_id;
         nb_ff      <= req_ch.nbr_id;
         now_ff     <= req_ch.now_ms;
         addr_ff    <= req_addr;
         node_ok_ff <= node_ext < XID_W'(NUM_NODES);
         nb_ok_ff   <= nb_ext < XID_W'(NUM_NODES);
         row_vld_ff <= (node_ext < XID_W'(NUM_NODES)) && row_valid_ff[req_addr];
      end
   end

   // ------------------------------------------------------------------
   // evaluate: parallel id match and age check over the row
   // ------------------------------------------------------------------
   always_comb begin
      logic [TIME_W-1:0] age;
      cnt_rd   = row_vld_ff ? ram_rd_data[ROW_W-1 -: CNT_W] : '0;
      ids_rd   = ram_rd_data[TIMS_W +: IDS_W];
      times_rd = ram_rd_data[TIMS_W-1:0];
      age      = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         // wrapped age, modulo 2^32
         age        = now_ff - times_rd[i];
         hit_in[i]  = (CNT_W'(i) < cnt_rd) && (ids_rd[i] == nb_ff);
         keep_in[i] = (CNT_W'(i) < cnt_rd) && (age <= timeout_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_EVAL) begin
         cnt_ff   <= cnt_rd;
         ids_ff   <= ids_rd;
         times_ff <= times_rd;
         hit_ff   <= hit_in;
         keep_ff  <= keep_in;
      end
   end

   // ------------------------------------------------------------------
   // modify: refresh, append or compact, and form the result
   // ------------------------------------------------------------------
   always_comb begin
      logic                         found;
      logic                         full;
      logic                         append;
      logic [CNT_W-1:0]             kept;
      logic [ENTRIES-1:0][CNT_W-1:0] pos;
      found      = |hit_ff;
      full       = (cnt_ff == CNT_W'(ENTRIES));
      append     = 1'b0;
      kept       = '0;
      pos        = '0;
      cnt_new    = cnt_ff;
      ids_new    = ids_ff;
      times_new  = times_ff;
      status_new = ST_NONE;
      removed_new = '0;

      // survivor slot of each entry: number of survivors ahead of it
      for (int r = 0; r < ENTRIES; r++) begin
         kept = kept + CNT_W'(keep_ff[r]);
         for (int j = 0; j < r; j++) begin
            pos[r] = pos[r] + CNT_W'(keep_ff[j]);
         end
      end

      case (mode_ff)
         MODE_TOUCH: begin
            if (node_ff == nb_ff) begin
               status_new = ST_SELF;
            end else if (!nb_ok_ff) begin
               status_new = ST_NONE;
            end else if (found) begin
               status_new = ST_REFRESHED;
               for (int i = 0; i < ENTRIES; i++) begin
                  if (hit_ff[i]) begin
                     times_new[i] = now_ff;
                  end
               end
            end else if (full) begin
               status_new = ST_FULL;
            end else begin
               status_new = ST_INSERTED;
               append     = 1'b1;
            end
         end
         MODE_ADD: begin
            // add takes self-links and never refreshes
            if (!nb_ok_ff || found) begin
               status_new = ST_NONE;
            end else if (full) begin
               status_new = ST_FULL;
            end else begin
               status_new = ST_INSERTED;
               append     = 1'b1;
            end
         end
         MODE_PRUNE: begin
            // survivors slide down in order, freed slots are zeroed
            for (int w = 0; w < ENTRIES; w++) begin
               ids_new[w]   = '0;
               times_new[w] = '0;
               for (int r = 0; r < ENTRIES; r++) begin
                  if (keep_ff[r] && (pos[r] == CNT_W'(w))) begin
                     ids_new[w]   = ids_new[w] | ids_ff[r];
                     times_new[w] = times_new[w] | times_ff[r];
                  end
               end
            end
            cnt_new     = kept;
            removed_new = cnt_ff - kept;
         end
         default: begin
            status_new = ST_NONE;
         end
      endcase

      if (append) begin
         for (int i = 0; i < ENTRIES; i++) begin
            if (CNT_W'(i) == cnt_ff) begin
               ids_new[i]   = nb_ff;
               times_new[i] = now_ff;
            end
         end
         cnt_new = cnt_ff + CNT_W'(1);
      end

      // presence after the operation
      if (mode_ff == MODE_PRUNE) begin
         reach_new = |(hit_ff & keep_ff);
      end else begin
         reach_new = found || append;
      end
   end

   // ------------------------------------------------------------------
   // sequencer and result register
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         rsp_valid_ff   <= 1'b0;
         rsp_status_ff  <= '0;
         rsp_reach_ff   <= 1'b0;
         rsp_count_ff   <= '0;
         rsp_removed_ff <= '0;
      end else begin
         if (rsp_valid_ff && rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  state_ff <= S_EVAL;
               end
            end
            S_EVAL: begin
               state_ff <= S_WRITE;
            end
            S_WRITE: begin
               if (commit) begin
                  state_ff     <= S_IDLE;
                  rsp_valid_ff <= 1'b1;
                  if (node_ok_ff) begin
                     rsp_status_ff  <= status_new;
                     rsp_reach_ff   <= reach_new;
                     rsp_count_ff   <= OCNT_W'(cnt_new);
                     rsp_removed_ff <= OCNT_W'(removed_new);
                  end else begin
                     // unknown node: item ignored
                     rsp_status_ff  <= ST_NONE;
                     rsp_reach_ff   <= 1'b0;
                     rsp_count_ff   <= '0;
                     rsp_removed_ff <= '0;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end
endmodule
